// ===== hw/rtl/frame_pacing_timer_core_defines.svh =====
// ----------------------------------------------------------------------------
// frame pacing timer assertion macros
// shared check helpers for the pacing core; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FRAME_PACING_TIMER_CORE_DEFINES_SVH
`define FRAME_PACING_TIMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition that must hold at every edge out of reset
`define FPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent in the cycle after the trigger
`define FPT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

// consequent in the same cycle as the trigger
`define FPT_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`else

`define FPT_ASSERT_ALWAYS(lbl, cond, msg)
`define FPT_ASSERT_NEXT(lbl, trig, cons, msg)
`define FPT_ASSERT_SAME(lbl, trig, cons, msg)

`endif

`endif

// ===== hw/rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// frame pacing timer package
// widths, reset constants, register map and shared types
// ----------------------------------------------------------------------------
package fpt_pkg;

  localparam int DUR_W    = 24;
  localparam int FPS_W    = 10;
  localparam int PERIOD_W = 20;
  localparam int BUSY_W   = 3;
  localparam int STEP_W   = 5;

  typedef logic [DUR_W-1:0]    dur_t;
  typedef logic [FPS_W-1:0]    fps_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [BUSY_W-1:0]   busy_t;
  typedef logic [STEP_W-1:0]   step_t;

  localparam period_t MICROS_PER_SEC = 20'd1000000;
  localparam fps_t    RESET_FPS      = 10'd15;
  localparam period_t RESET_PERIOD   = 20'd66666;
  localparam busy_t   BUSY_LIMIT     = 3'd3;
  localparam step_t   DIV_STEPS      = 5'd20;

  // command codes
  localparam logic CMD_FRAME_END = 1'b0;
  localparam logic CMD_TICK      = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_FPS = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/frame_pacing_timer_core.sv =====
// ----------------------------------------------------------------------------
// frame_pacing_timer_core
// Moving-average frame pacer. Takes one item per cycle while in_stall is low
// and returns one result per item: the accept cycle shifts a frame end's
// duration into the chain of window cells and updates the running sum, the
// next stage forms the window average by a reciprocal multiply, and the last
// stage applies the tick rule and the busy count. A write of required_fps
// starts a restoring divider for the target period, then every window cell
// is refilled; input is stalled while the divider runs and during the
// refill. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "frame_pacing_timer_core_defines.svh"

module frame_pacing_timer_core #(
  parameter int WINDOW_SIZE = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  fpt_pkg::dur_t         frame_time_us,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output fpt_pkg::dur_t         next_interval_us,
  output logic                  fire_frame,
  output fpt_pkg::dur_t         average_frame_us,
  output fpt_pkg::busy_t        frames_in_flight
);
  import fpt_pkg::*;

  localparam int LOG_W  = $clog2(WINDOW_SIZE);
  localparam int SUM_W  = DUR_W + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int PROD_W = 2 * SUM_W + 1;
  // exact floor division by the window size for every sum of SUM_W bits
  localparam logic [64:0] RECIP_FULL =
    ((65'd1 << SHIFT) + 65'(WINDOW_SIZE) - 65'd1) / 65'(WINDOW_SIZE);
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

  fps_t             required_fps;
  period_t          target_period;
  period_t          div_quot;
  div_stat_t        div_stat;
  logic             cfg_wr;

  logic             in_accept;
  logic             out_ready;
  logic             s2_ready;
  logic             s1_ready;
  logic [SUM_W-1:0] sum_next;

  logic             s1_valid;
  logic             s1_cmd;
  logic [SUM_W-1:0] s1_sum;
  logic [PROD_W-1:0] product;

  logic             s2_valid;
  logic             s2_cmd;
  dur_t             s2_avg;

  dur_t             pacing_interval;
  dur_t             pacing_interval_next;
  busy_t            busy_count;
  busy_t            busy_count_next;
  logic             fire_next;
  logic             end_load;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FPS);
  assign prdata = (paddr[2] == REG_FPS) ? {{(32-FPS_W){1'b0}}, required_fps} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      required_fps  <= RESET_FPS;
      target_period <= RESET_PERIOD;
    end else begin
      if (cfg_wr) begin
        required_fps <= pwdata[FPS_W-1:0];
      end
      if (div_stat.done) begin
        target_period <= div_quot;
      end
    end
  end

  fpt_period_div u_period_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_wr),
    .fps      (pwdata[FPS_W-1:0]),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // pipeline flow: a stage takes new data when empty or when it drains
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready || div_stat.busy || div_stat.done;
  assign in_accept = in_valid && !in_stall;

  fpt_window #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept && (cmd == CMD_FRAME_END)),
    .refill   (div_stat.done),
    .dur      (frame_time_us),
    .target   (div_quot),
    .sum_next (sum_next)
  );

  // stage 1: sum after the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_accept) begin
      s1_cmd <= cmd;
      s1_sum <= sum_next;
    end
  end

  // stage 2: window average
  assign product = PROD_W'(s1_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_cmd <= s1_cmd;
      s2_avg <= product[SHIFT +: DUR_W];
    end
  end

  // stage 3: pacing rule and busy count
  always_comb begin
    pacing_interval_next = pacing_interval;
    busy_count_next      = busy_count;
    fire_next            = 1'b0;
    if (s2_cmd == CMD_TICK) begin
      if (s2_avg > DUR_W'(target_period)) begin
        pacing_interval_next = s2_avg >> 1;
      end else begin
        pacing_interval_next = DUR_W'(target_period);
      end
      if (busy_count <= BUSY_LIMIT) begin
        busy_count_next = busy_count + busy_t'(1);
        fire_next       = 1'b1;
      end
    end else if (busy_count != '0) begin
      busy_count_next = busy_count - busy_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      pacing_interval <= DUR_W'(RESET_PERIOD);
      busy_count      <= '0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        pacing_interval <= pacing_interval_next;
        busy_count      <= busy_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      next_interval_us <= pacing_interval_next;
      fire_frame       <= fire_next;
      average_frame_us <= s2_avg;
      frames_in_flight <= busy_count_next;
    end
  end

  // a frame end moving into the output register
  assign end_load = out_ready && s2_valid && (s2_cmd == CMD_FRAME_END);

  `FPT_ASSERT_ALWAYS(a_busy_bound, busy_count <= BUSY_LIMIT + busy_t'(1), "busy count high")
  `FPT_ASSERT_SAME(a_fire_counted, out_valid && fire_frame, frames_in_flight != '0, "empty fire")
  `FPT_ASSERT_NEXT(a_cfg_blocks, cfg_wr, in_stall, "item taken during period update")
  `FPT_ASSERT_NEXT(a_end_no_fire, end_load, !fire_frame, "frame end fired")

endmodule

// ===== hw/rtl/fpt_cell.sv =====
// ----------------------------------------------------------------------------
// fpt_cell
// one duration slot of the window chain; shifts toward the oldest end
// ----------------------------------------------------------------------------
module fpt_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic         load,
  input  fpt_pkg::dur_t shift_in,
  input  fpt_pkg::dur_t load_val,
  output fpt_pkg::dur_t val
);
  import fpt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= DUR_W'(RESET_PERIOD);
    end else if (load) begin
      val <= load_val;
    end else if (shift) begin
      val <= shift_in;
    end
  end

endmodule

// ===== hw/rtl/fpt_window.sv =====
// ----------------------------------------------------------------------------
// fpt_window
// chain of duration cells with the running sum of their contents
// ----------------------------------------------------------------------------
module fpt_window #(
  parameter int WINDOW_SIZE = 8,
  parameter int SUM_W       = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             refill,
  input  fpt_pkg::dur_t    dur,
  input  fpt_pkg::period_t target,
  output logic [SUM_W-1:0] sum_next
);
  import fpt_pkg::*;

  dur_t             vals [WINDOW_SIZE];
  logic [SUM_W-1:0] sum;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    dur_t chain_in;
    if (i == 0) begin : g_head
      assign chain_in = dur;
    end else begin : g_link
      assign chain_in = vals[i-1];
    end
    fpt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (push),
      .load     (refill),
      .shift_in (chain_in),
      .load_val (DUR_W'(target)),
      .val      (vals[i])
    );
  end

  // last cell holds the oldest duration
  always_comb begin
    if (push) begin
      sum_next = sum - SUM_W'(vals[WINDOW_SIZE-1]) + SUM_W'(dur);
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= SUM_W'(RESET_PERIOD) * SUM_W'(WINDOW_SIZE);
    end else if (refill) begin
      sum <= SUM_W'(target) * SUM_W'(WINDOW_SIZE);
    end else begin
      sum <= sum_next;
    end
  end

endmodule

// ===== hw/rtl/fpt_period_div.sv =====
// ----------------------------------------------------------------------------
// fpt_period_div
// restoring divider, one quotient bit per cycle: 1000000 / fps
// ----------------------------------------------------------------------------
module fpt_period_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fpt_pkg::fps_t        fps,
  output fpt_pkg::period_t     quotient,
  output fpt_pkg::div_stat_t   stat
);
  import fpt_pkg::*;

  step_t          cnt;
  fps_t           divisor;
  logic [FPS_W-1:0] rem;
  logic [FPS_W:0]   trial;
  logic             ge;
  logic [FPS_W:0]   diff;
  logic             done;

  // quotient register starts as the dividend and shifts quotient bits in
  always_comb begin
    trial = {rem, quotient[PERIOD_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  assign stat = {cnt != '0, done};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_STEPS;
      done <= 1'b0;
    end else begin
      done <= cnt == step_t'(1);
      if (cnt != '0) begin
        cnt <= cnt - step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor  <= (fps == '0) ? fps_t'(1) : fps;
      rem      <= '0;
      quotient <= MICROS_PER_SEC;
    end else if (cnt != '0) begin
      rem      <= ge ? diff[FPS_W-1:0] : trial[FPS_W-1:0];
      quotient <= {quotient[PERIOD_W-2:0], ge};
    end
  end

endmodule
